FILE: hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tiled texture swizzle package
// Shared types, constants and the pixel format conversion of the swizzle core.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

   // Largest supported image side, as a power-of-two exponent.
   localparam int MAX_DIM_LOG2 = 6;
   localparam int MIN_DIM_LOG2 = 3;

   // Pixel store geometry and counter widths.
   localparam int ADDR_W  = 2 * MAX_DIM_LOG2;
   localparam int CNT_W   = ADDR_W + 1;
   localparam int LOG_W   = $clog2(MAX_DIM_LOG2 + 1);
   localparam int PIXEL_W = 32;
   localparam int TEXEL_W = 16;
   localparam int DST_W   = 12;
   localparam int TILE_LOG2 = 3;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LOG2  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_LOG2 = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  CSR_DIM_RESET   = 3'd6;

   // Transaction modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EMIT = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [PIXEL_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [TEXEL_W-1:0] texel;
      logic [DST_W-1:0]   dst_index;
      logic               last;
   } rsp_type;

   // Command from the sequencer to the store and the result path.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DST_W-1:0]  dst_index;
      logic              last;
   } mem_cmd_type;

   // Out-of-range size codes saturate to the supported range.
   function automatic logic [LOG_W-1:0] clamp_log2(input logic [CSR_DATA_W-1:0] v);
      logic [LOG_W:0] ve;
      ve = (LOG_W + 1)'(v);
      if (ve < (LOG_W + 1)'(MIN_DIM_LOG2)) begin
         return LOG_W'(MIN_DIM_LOG2);
      end else if (ve > (LOG_W + 1)'(MAX_DIM_LOG2)) begin
         return LOG_W'(MAX_DIM_LOG2);
      end
      return LOG_W'(ve);
   endfunction

   // ABGR8888 to RGBA5551; alpha bit is set by any nonzero source alpha.
   function automatic logic [TEXEL_W-1:0] to_rgba5551(input logic [PIXEL_W-1:0] p);
      return {p[7:3], p[15:11], p[23:19], |p[31:24]};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/texture_tile_swizzle_rgba5551_core.sv
// ----------------------------------------------------------------------------
// Tiled texture swizzle core with RGBA5551 conversion
// Loads a row-major ABGR8888 image and streams it out in 8x8 Morton tiles.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes the next source pixel into a 4096-word
// pixel store; it gives no result. Once the whole image is loaded, each emit
// transaction (mode 1) reads one texel in tiled order, flipped vertically,
// converts it to RGBA5551 and returns it with its output position and a last
// flag on the final texel. An emit passes the store's registered read, then
// moves the texel into the result register. Requests wait while a read result
// is held in the store's output register; loads are otherwise accepted every
// cycle. A finished texel waiting in the result register does not block the
// request side; one more emit may be read behind it. Loads beyond the image
// and emits before the image is complete are accepted and dropped. Writing
// either size register restarts the image load. The store has no reset and
// no clearing pass; the counters ensure that only loaded entries are read.
`default_nettype none

module texture_tile_swizzle_rgba5551_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [tts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire tts_pkg::req_type                req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      tts_pkg::rsp_type                rsp_data
);
   import tts_pkg::*;

   mem_cmd_type        cmd;
   logic               accept;
   logic [PIXEL_W-1:0] rdata;

   // A read result waiting in the store's output register.
   logic               data_pend_ff, data_pend_in;
   logic [DST_W-1:0]   meta_index_ff;
   logic               meta_last_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;
   logic               out_free, move;

   assign req_ready = !data_pend_ff;
   assign accept    = req_valid && req_ready;

   tts_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .mode         (req_data.mode),
      .cmd          (cmd)
   );

   tts_ram #(
      .DEPTH_LOG2 (ADDR_W),
      .DATA_W     (PIXEL_W)
   ) u_ram (
      .clock (clock),
      .wr_en (cmd.wr_en),
      .rd_en (cmd.rd_en),
      .addr  (cmd.addr),
      .wdata (req_data.pixel),
      .rdata (rdata)
   );

   // The texel moves on when the result register is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign move     = data_pend_ff && out_free;

   always_comb begin
      data_pend_in = cmd.rd_en || (data_pend_ff && !move);
      rsp_valid_in = move || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (move) begin
         rsp_data_in.texel     = to_rgba5551(rdata);
         rsp_data_in.dst_index = meta_index_ff;
         rsp_data_in.last      = meta_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         data_pend_ff <= data_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.rd_en) begin
         meta_index_ff <= cmd.dst_index;
         meta_last_ff  <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An issued read always leaves a pending texel behind it.
   assert property (@(posedge clock) disable iff (reset) cmd.rd_en |=> data_pend_ff)
      else $error("store read issued without pending texel");

   // A pending texel is not dropped while the result register is stalled.
   assert property (@(posedge clock) disable iff (reset)
      data_pend_ff && rsp_valid && !rsp_ready |=> data_pend_ff && rsp_valid)
      else $error("pending texel lost under stall");

   // A new result only appears from a pending read.
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(data_pend_ff))
      else $error("result without store read");

endmodule

`default_nettype wire

FILE: hdl/tts_ram.sv
// ----------------------------------------------------------------------------
// Tiled texture swizzle pixel store
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
   parameter int DEPTH_LOG2 = 12,
   parameter int DATA_W     = 32
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic                  rd_en,
   input  wire logic [DEPTH_LOG2-1:0] addr,
   input  wire logic [DATA_W-1:0]     wdata,
   output      logic [DATA_W-1:0]     rdata
);

   logic [DATA_W-1:0] mem [2**DEPTH_LOG2];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/tts_seq.sv
// ----------------------------------------------------------------------------
// Tiled texture swizzle sequencer
// Size registers, load and emit counters, and the tiled source address.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_seq (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [tts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               accept,
   input  wire logic                               mode,
   output      tts_pkg::mem_cmd_type               cmd
);
   import tts_pkg::*;

   logic [CSR_DATA_W-1:0] width_log2_ff,  width_log2_in;
   logic [CSR_DATA_W-1:0] height_log2_ff, height_log2_in;
   logic [CNT_W-1:0]      load_count_ff,  load_count_in;
   logic [CNT_W-1:0]      emit_count_ff,  emit_count_in;

   logic [LOG_W-1:0]      wl, hl, trl;
   logic [LOG_W:0]        dim_sum;
   logic [CNT_W-1:0]      total;
   logic                  full, is_last, do_load, do_emit;
   logic [5:0]            k;
   logic [CNT_W-7:0]      t, tile_x, tile_y;
   logic [2:0]            mx, my;
   logic [ADDR_W-1:0]     x, y, ymir, height, src;

   assign wl     = clamp_log2(width_log2_ff);
   assign hl     = clamp_log2(height_log2_ff);
   // The exponent sum reaches 12, so it needs one bit more than either term.
   assign dim_sum = {1'b0, wl} + {1'b0, hl};
   assign total  = CNT_W'(1) << dim_sum;
   assign full   = (load_count_ff == total);
   assign is_last = (emit_count_ff == total - CNT_W'(1));

   assign do_load = accept && (mode == MODE_LOAD) && !full;
   assign do_emit = accept && (mode == MODE_EMIT) && full && (emit_count_ff < total);

   // Tile-major position with Morton order inside the 8x8 tile.
   assign k      = emit_count_ff[5:0];
   assign t      = emit_count_ff[CNT_W-1:6];
   assign trl    = wl - LOG_W'(TILE_LOG2);
   assign tile_x = t & ((CNT_W-6)'(1) << trl) - (CNT_W-6)'(1);
   assign tile_y = t >> trl;
   assign mx     = {k[4], k[2], k[0]};
   assign my     = {k[5], k[3], k[1]};
   assign x      = ADDR_W'({tile_x, mx});
   assign y      = ADDR_W'({tile_y, my});
   assign height = ADDR_W'(CNT_W'(1) << hl);
   assign ymir   = height - ADDR_W'(1) - y;
   assign src    = x + (ymir << wl);

   always_comb begin
      cmd.wr_en     = do_load;
      cmd.rd_en     = do_emit;
      cmd.addr      = do_load ? load_count_ff[ADDR_W-1:0] : src;
      cmd.dst_index = DST_W'(emit_count_ff);
      cmd.last      = is_last;
   end

   always_comb begin
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      load_count_in  = load_count_ff;
      emit_count_in  = emit_count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WIDTH_LOG2:  width_log2_in  = csr_wdata;
            CSR_HEIGHT_LOG2: height_log2_in = csr_wdata;
            default:         width_log2_in  = width_log2_ff;
         endcase
         load_count_in = '0;
         emit_count_in = '0;
      end else if (do_load) begin
         load_count_in = load_count_ff + CNT_W'(1);
      end else if (do_emit) begin
         if (is_last) begin
            load_count_in = '0;
            emit_count_in = '0;
         end else begin
            emit_count_in = emit_count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= CSR_DIM_RESET;
         height_log2_ff <= CSR_DIM_RESET;
         load_count_ff  <= '0;
         emit_count_ff  <= '0;
      end else begin
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
         load_count_ff  <= load_count_in;
         emit_count_ff  <= emit_count_in;
      end
   end

   // A transaction never both writes and reads the store.
   assert property (@(posedge clock) disable iff (reset) !(cmd.wr_en && cmd.rd_en))
      else $error("store written and read by one transaction");

   // The final texel returns both counters to zero.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en && cmd.last && !csr_write_en |=> load_count_ff == '0 && emit_count_ff == '0)
      else $error("counters not cleared after final texel");

   // Counters stay inside the image.
   assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= total && emit_count_ff < total)
      else $error("counter beyond image size");

endmodule

`default_nettype wire
